/* src/chroma_key_estimator_assert.svh */
// Assertion macros for the chroma key estimator.
// Taken in by the RTL files that carry concurrent assertions.
`ifndef CHROMA_KEY_ESTIMATOR_ASSERT_SVH
`define CHROMA_KEY_ESTIMATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define CKE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("chroma key estimator check failed");
`define CKE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("chroma key estimator check failed");
`else
`define CKE_ASSERT(lbl, clk, rstn, prop)
`define CKE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* src/cke_pkg.sv */
// Shared constants of the chroma key estimator: register indexes,
// pitch-class boundary constants and the key templates. No dependencies.
package cke_pkg;

    localparam int BIN_COUNT_W = 13;
    localparam int SR_W        = 18;
    localparam int CFG_DATA_W  = 18;
    localparam int CFG_IDX_W   = 1;
    localparam int EDGE_W      = 21;
    localparam int TPL_W       = 10;
    localparam int NUM_PC      = 12;
    localparam int PC_W        = 4;
    localparam int OCT_MAX     = 10;
    localparam int Q_W         = 17;
    localparam int CONF_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 1'd1;

    localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RESET   = 13'd1024;
    localparam logic [SR_W-1:0]        SAMPLE_RATE_RESET = 18'd48000;

    localparam int BAND_LOW_HZ   = 20;
    localparam int BAND_HIGH_HZ  = 20000;
    localparam int TPL_SUM       = 8630;
    localparam int CONF_HALF     = 32768;

    function automatic logic [EDGE_W-1:0] edge_q16(input logic [PC_W-1:0] idx);
        logic [EDGE_W-1:0] val;
        case (idx)
            4'd0:    val = 21'd1041111;
            4'd1:    val = 21'd1103019;
            4'd2:    val = 21'd1168608;
            4'd3:    val = 21'd1238097;
            4'd4:    val = 21'd1311718;
            4'd5:    val = 21'd1389717;
            4'd6:    val = 21'd1472354;
            4'd7:    val = 21'd1559905;
            4'd8:    val = 21'd1652661;
            4'd9:    val = 21'd1750934;
            4'd10:   val = 21'd1855050;
            4'd11:   val = 21'd1965357;
            default: val = '0;
        endcase
        return val;
    endfunction

    function automatic logic [TPL_W-1:0] tpl_major(input logic [PC_W-1:0] idx);
        logic [TPL_W-1:0] val;
        case (idx)
            4'd0:    val = 10'd635;
            4'd1:    val = 10'd223;
            4'd2:    val = 10'd348;
            4'd3:    val = 10'd233;
            4'd4:    val = 10'd438;
            4'd5:    val = 10'd409;
            4'd6:    val = 10'd252;
            4'd7:    val = 10'd519;
            4'd8:    val = 10'd239;
            4'd9:    val = 10'd366;
            4'd10:   val = 10'd229;
            4'd11:   val = 10'd288;
            default: val = '0;
        endcase
        return val;
    endfunction

    function automatic logic [TPL_W-1:0] tpl_minor(input logic [PC_W-1:0] idx);
        logic [TPL_W-1:0] val;
        case (idx)
            4'd0:    val = 10'd633;
            4'd1:    val = 10'd268;
            4'd2:    val = 10'd352;
            4'd3:    val = 10'd538;
            4'd4:    val = 10'd260;
            4'd5:    val = 10'd353;
            4'd6:    val = 10'd254;
            4'd7:    val = 10'd475;
            4'd8:    val = 10'd398;
            4'd9:    val = 10'd269;
            4'd10:   val = 10'd334;
            4'd11:   val = 10'd317;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

/* src/chroma_key_estimator.sv */
// Chroma key estimator: builds a pitch-class profile from spectrum bins and
// scores it against major and minor key templates. Uses cke_pkg.
//
// A bin whose frequency lies in the audible band goes through the octave and
// pitch-class searches and a read and a write of the accumulator memory
// before the next bin can be accepted; a skipped bin skips these. The
// pitch-class search steps one boundary per cycle, comparing against the
// product of the denominator and a boundary constant. The last bin of a
// frame then adds 144 memory reads for the twelve rotations, a short drain,
// and a 17-step divider for the confidence. A finished result waits in the
// output register while the next frame is accepted.
`include "chroma_key_estimator_assert.svh"

module chroma_key_estimator
    import cke_pkg::*;
#(
    parameter int MAX_BINS  = 4096,
    parameter int MAG_WIDTH = 16,
    parameter int ACC_WIDTH = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        bin_valid,
    output logic                        bin_stall,
    input  logic signed [MAG_WIDTH-1:0] bin_magnitude,
    output logic                        key_valid,
    input  logic                        key_stall,
    output logic [3:0]                  key_root,
    output logic                        key_minor,
    output logic [CONF_W-1:0]           confidence,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int POS_W  = $clog2(MAX_BINS);
    localparam int CNT_W  = $clog2(MAX_BINS + 1);
    localparam int DEN_W  = CNT_W + 1;
    localparam int V_W    = POS_W + SR_W;
    localparam int W_W    = V_W + 16;
    localparam int THR_W  = DEN_W + EDGE_W + OCT_MAX + 1;
    localparam int CMP_W  = (W_W > THR_W) ? W_W : THR_W;
    localparam int PROD_W = ACC_WIDTH + TPL_W;
    localparam int SC_W   = PROD_W + 4;
    localparam int TOT_W  = ACC_WIDTH + 4;
    localparam int DIV_W  = TOT_W + 14;
    localparam int REM_W  = DIV_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_BAND,
        ST_OCT,
        ST_CLS,
        ST_RD,
        ST_WR,
        ST_SCORE,
        ST_DRAIN,
        ST_DIVINIT,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic [BIN_COUNT_W-1:0] bin_count_reg;
    logic [SR_W-1:0]        sample_rate_reg;
    logic [POS_W-1:0]       bin_position_reg;

    logic [MAG_WIDTH-1:0]   mag_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [DEN_W-1:0]       den_reg;
    logic                   last_reg;
    logic [V_W-1:0]         v_reg;
    logic [DEN_W+EDGE_W-1:0] base_reg;
    logic [3:0]             oct_reg;
    logic [PC_W-1:0]        j_reg;
    logic [PC_W-1:0]        pc_reg;

    logic [ACC_WIDTH-1:0]   mem [NUM_PC];
    logic [ACC_WIDTH-1:0]   rd_q_reg;
    logic                   rd_valid_reg;
    logic [NUM_PC-1:0]      acc_valid_reg;
    logic                   rd_en;
    logic [PC_W-1:0]        rd_addr;
    logic                   wr_en;
    logic [ACC_WIDTH-1:0]   wr_data;

    logic [PC_W-1:0]        r_reg;
    logic [PC_W-1:0]        i_reg;
    logic                   s1_valid_reg;
    logic [PC_W-1:0]        s1_i_reg;
    logic [PC_W-1:0]        s1_r_reg;
    logic                   s2_valid_reg;
    logic [PC_W-1:0]        s2_i_reg;
    logic [PC_W-1:0]        s2_r_reg;
    logic [ACC_WIDTH-1:0]   s2_data_reg;
    logic [PROD_W-1:0]      p_maj_reg;
    logic [PROD_W-1:0]      p_min_reg;
    logic                   s3_done_reg;
    logic [PC_W-1:0]        s3_r_reg;
    logic [SC_W-1:0]        smaj_reg;
    logic [SC_W-1:0]        smin_reg;
    logic [TOT_W-1:0]       total_reg;
    logic [SC_W-1:0]        best_reg;
    logic                   have_reg;
    logic [PC_W-1:0]        root_reg;
    logic                   minor_reg;

    logic [REM_W-1:0]       rem_reg;
    logic [DIV_W-1:0]       div_reg;
    logic [Q_W-1:0]         q_reg;
    logic [4:0]             step_reg;
    logic [CONF_W-1:0]      conf_reg;

    logic                   key_valid_reg;
    logic [3:0]             key_root_reg;
    logic                   key_minor_reg;
    logic [CONF_W-1:0]      confidence_reg;

    logic [CNT_W-1:0]       eff_count;
    logic                   frame_last;
    logic [CMP_W-1:0]       w_cmp;
    logic                   skip_bin;
    logic [3:0]             oct_next;
    logic [CMP_W-1:0]       thr_cmp;
    logic [ACC_WIDTH-1:0]   mag_ext;
    logic [ACC_WIDTH-1:0]   acc_old;
    logic [ACC_WIDTH:0]     acc_sum;
    logic [PC_W:0]          idx_sum;
    logic [PC_W-1:0]        score_idx;
    logic [ACC_WIDTH-1:0]   score_data;
    logic                   take_maj;
    logic [SC_W-1:0]        best_mid;
    logic                   take_min;
    logic [REM_W-1:0]       rem_sh;
    logic [Q_W:0]           q_round;

    always_comb
    begin
        if (bin_count_reg == '0)
            eff_count = CNT_W'(1);
        else if (int'(bin_count_reg) > MAX_BINS)
            eff_count = CNT_W'(MAX_BINS);
        else
            eff_count = CNT_W'(bin_count_reg);
        frame_last = CNT_W'(bin_position_reg) >= (eff_count - CNT_W'(1));

        w_cmp = CMP_W'(v_reg) << 16;
        skip_bin = (pos_reg == '0)
                || (CMP_W'(v_reg) <= CMP_W'(den_reg * BAND_LOW_HZ))
                || (CMP_W'(v_reg) >= CMP_W'(den_reg * BAND_HIGH_HZ));

        oct_next = '0;
        for (int k = 1; k <= OCT_MAX; k++)
        begin
            if ((CMP_W'(base_reg) << k) <= w_cmp)
                oct_next = 4'(k);
        end

        thr_cmp = (CMP_W'(den_reg) * CMP_W'(edge_q16(j_reg))) << oct_reg;

        mag_ext = mag_reg[MAG_WIDTH-1] ? '0 : ACC_WIDTH'(unsigned'(mag_reg));
        acc_old = rd_valid_reg ? rd_q_reg : '0;
        acc_sum = {1'b0, acc_old} + (ACC_WIDTH+1)'(mag_ext);
        wr_data = acc_sum[ACC_WIDTH] ? '1 : acc_sum[ACC_WIDTH-1:0];

        idx_sum   = {1'b0, i_reg} + {1'b0, r_reg};
        score_idx = (idx_sum >= (PC_W+1)'(NUM_PC)) ? PC_W'(idx_sum - (PC_W+1)'(NUM_PC))
                                                   : PC_W'(idx_sum);
        score_data = rd_valid_reg ? rd_q_reg : '0;

        take_maj = !have_reg || (smaj_reg > best_reg);
        best_mid = take_maj ? smaj_reg : best_reg;
        take_min = smin_reg > best_mid;

        rem_sh  = {rem_reg[REM_W-2:0], 1'b0};
        q_round = {1'b0, q_reg} + (Q_W+1)'(1);

        rd_en   = (state_reg == ST_RD) || (state_reg == ST_SCORE);
        rd_addr = (state_reg == ST_SCORE) ? score_idx : pc_reg;
        wr_en   = (state_reg == ST_WR);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[pc_reg] <= wr_data;
        if (rd_en)
            rd_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            bin_count_reg    <= BIN_COUNT_RESET;
            sample_rate_reg  <= SAMPLE_RATE_RESET;
            bin_position_reg <= '0;
            acc_valid_reg    <= '0;
            rd_valid_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_done_reg      <= 1'b0;
            key_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_BIN_COUNT:   bin_count_reg   <= cfg_data[BIN_COUNT_W-1:0];
                    REG_SAMPLE_RATE: sample_rate_reg <= cfg_data[SR_W-1:0];
                    default:         ;
                endcase
            end

            if (key_valid_reg && !key_stall && (state_reg != ST_EMIT))
                key_valid_reg <= 1'b0;

            if (rd_en)
                rd_valid_reg <= acc_valid_reg[rd_addr];

            s1_valid_reg <= (state_reg == ST_SCORE);
            s1_i_reg     <= i_reg;
            s1_r_reg     <= r_reg;

            s2_valid_reg <= s1_valid_reg;
            s2_i_reg     <= s1_i_reg;
            s2_r_reg     <= s1_r_reg;
            s2_data_reg  <= score_data;
            p_maj_reg    <= score_data * tpl_major(s1_i_reg);
            p_min_reg    <= score_data * tpl_minor(s1_i_reg);

            s3_done_reg <= s2_valid_reg && (s2_i_reg == PC_W'(NUM_PC - 1));
            s3_r_reg    <= s2_r_reg;
            if (s2_valid_reg)
            begin
                if (s2_i_reg == '0)
                begin
                    smaj_reg <= SC_W'(p_maj_reg);
                    smin_reg <= SC_W'(p_min_reg);
                end
                else
                begin
                    smaj_reg <= smaj_reg + SC_W'(p_maj_reg);
                    smin_reg <= smin_reg + SC_W'(p_min_reg);
                end
                if (s2_r_reg == '0)
                    total_reg <= total_reg + TOT_W'(s2_data_reg);
            end

            if (s3_done_reg)
            begin
                have_reg <= 1'b1;
                if (take_min)
                begin
                    best_reg  <= smin_reg;
                    root_reg  <= s3_r_reg;
                    minor_reg <= 1'b1;
                end
                else if (take_maj)
                begin
                    best_reg  <= smaj_reg;
                    root_reg  <= s3_r_reg;
                    minor_reg <= 1'b0;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (bin_valid)
                    begin
                        mag_reg  <= bin_magnitude;
                        pos_reg  <= bin_position_reg;
                        den_reg  <= {eff_count, 1'b0};
                        last_reg <= frame_last;
                        bin_position_reg <= frame_last ? '0 : bin_position_reg + POS_W'(1);
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    v_reg     <= V_W'(pos_reg) * V_W'(sample_rate_reg);
                    state_reg <= ST_BAND;
                end
                ST_BAND:
                begin
                    base_reg <= den_reg * edge_q16(PC_W'(0));
                    if (!skip_bin)
                        state_reg <= ST_OCT;
                    else if (last_reg)
                    begin
                        r_reg     <= '0;
                        i_reg     <= '0;
                        total_reg <= '0;
                        have_reg  <= 1'b0;
                        state_reg <= ST_SCORE;
                    end
                    else
                        state_reg <= ST_IDLE;
                end
                ST_OCT:
                begin
                    oct_reg   <= oct_next;
                    j_reg     <= PC_W'(1);
                    pc_reg    <= '0;
                    state_reg <= ST_CLS;
                end
                ST_CLS:
                begin
                    if (thr_cmp <= w_cmp)
                        pc_reg <= j_reg;
                    if (j_reg == PC_W'(NUM_PC - 1))
                        state_reg <= ST_RD;
                    else
                        j_reg <= j_reg + PC_W'(1);
                end
                ST_RD:
                begin
                    state_reg <= ST_WR;
                end
                ST_WR:
                begin
                    acc_valid_reg[pc_reg] <= 1'b1;
                    if (last_reg)
                    begin
                        r_reg     <= '0;
                        i_reg     <= '0;
                        total_reg <= '0;
                        have_reg  <= 1'b0;
                        state_reg <= ST_SCORE;
                    end
                    else
                        state_reg <= ST_IDLE;
                end
                ST_SCORE:
                begin
                    if (i_reg == PC_W'(NUM_PC - 1))
                    begin
                        i_reg <= '0;
                        if (r_reg == PC_W'(NUM_PC - 1))
                            state_reg <= ST_DRAIN;
                        else
                            r_reg <= r_reg + PC_W'(1);
                    end
                    else
                        i_reg <= i_reg + PC_W'(1);
                end
                ST_DRAIN:
                begin
                    if (!s1_valid_reg && !s2_valid_reg && !s3_done_reg)
                        state_reg <= ST_DIVINIT;
                end
                ST_DIVINIT:
                begin
                    acc_valid_reg <= '0;
                    rem_reg  <= REM_W'(best_reg) * REM_W'(12);
                    div_reg  <= DIV_W'(total_reg) * DIV_W'(TPL_SUM);
                    q_reg    <= '0;
                    step_reg <= '0;
                    if (total_reg == '0)
                    begin
                        conf_reg  <= CONF_W'(CONF_HALF);
                        state_reg <= ST_EMIT;
                    end
                    else
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (rem_sh >= {1'b0, div_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, div_reg};
                        q_reg   <= {q_reg[Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        q_reg   <= {q_reg[Q_W-2:0], 1'b0};
                    end
                    if (step_reg == 5'(Q_W - 1))
                        state_reg <= ST_EMIT;
                    else
                        step_reg <= step_reg + 5'd1;
                end
                ST_EMIT:
                begin
                    if (conf_reg == '0 && q_reg != '0 && total_reg != '0)
                        conf_reg <= '0;
                    if (!key_valid_reg || !key_stall)
                    begin
                        key_valid_reg <= 1'b1;
                        key_root_reg  <= root_reg;
                        key_minor_reg <= minor_reg;
                        if (total_reg == '0)
                            confidence_reg <= conf_reg;
                        else if (q_round[Q_W])
                            confidence_reg <= '1;
                        else
                            confidence_reg <= q_round[CONF_W:1];
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign bin_stall  = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign key_valid  = key_valid_reg;
    assign key_root   = key_root_reg;
    assign key_minor  = key_minor_reg;
    assign confidence = confidence_reg;

    `CKE_ASSERT(a_pos_range, clk, rst_n, int'(bin_position_reg) < MAX_BINS)
    `CKE_ASSERT(a_wr_addr, clk, rst_n, !wr_en || (pc_reg < PC_W'(NUM_PC)))
    `CKE_ASSERT(a_score_idx, clk, rst_n,
        (state_reg != ST_SCORE) || (score_idx < PC_W'(NUM_PC)))
    `CKE_ASSERT_NEXT(a_clear_after_score, clk, rst_n,
        state_reg == ST_DIVINIT, acc_valid_reg == '0)
    `CKE_ASSERT_NEXT(a_emit_loads, clk, rst_n,
        (state_reg == ST_EMIT) && !key_stall, key_valid_reg && (state_reg == ST_IDLE))

endmodule
